FILE: hdl/l2_vector_normalizer_unit_macros.svh
// ----------------------------------------------------------------------------
// L2 vector normalizer assertion macros
// Shared property forms for the checker; clk and arst_n come from the scope.
// ----------------------------------------------------------------------------
`ifndef L2_VECTOR_NORMALIZER_UNIT_MACROS_SVH
`define L2_VECTOR_NORMALIZER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define L2VN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define L2VN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/l2vn_pkg.sv
// ----------------------------------------------------------------------------
// L2 vector normalizer package
// Sizes, state types, result record and shared helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package l2vn_pkg;

	localparam int unsigned MAX_CHANNELS = 64;
	localparam int unsigned SAMPLE_BITS  = 16;

	localparam int unsigned FRAC   = SAMPLE_BITS - 1;
	localparam int unsigned SHIFT  = 31 - FRAC;
	localparam int unsigned ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_CHANNELS + 1);
	localparam int unsigned SQ_W   = 2 * SAMPLE_BITS;
	localparam int unsigned SUM_W  = 2 * SAMPLE_BITS - 2 + CNT_W;

	localparam int unsigned QUO_W   = 63;
	localparam int unsigned QSTEP_W = $clog2(QUO_W);
	localparam int unsigned ROOT_W  = 32;
	localparam int unsigned RSTEP_W = $clog2(ROOT_W);
	localparam int unsigned WORK_W  = 2 * ROOT_W;

	localparam int unsigned PROD_W = SAMPLE_BITS + ROOT_W;
	localparam int unsigned Y_W    = PROD_W + 1 - SHIFT;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [SAMPLE_BITS-1:0] SAT_POS = SAMPLE_BITS'((64'd1 << FRAC) - 64'd1);
	localparam logic [SAMPLE_BITS-1:0] SAT_NEG = SAMPLE_BITS'(64'd1 << FRAC);
	localparam logic [PROD_W:0] ROUND_ADD =
		(SHIFT > 0) ? (PROD_W + 1)'(64'd1 << ((SHIFT > 0) ? SHIFT - 1 : 0)) : '0;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_FINISH,
		ST_SCALE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		RS_IDLE,
		RS_DIV,
		RS_ROOT,
		RS_DONE
	} rs_state_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} rs_stat_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] normalized;
		logic                          last_of_run;
		logic                          zero_norm;
		logic                          overflow;
	} res_t;

	function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] x);
		return x[SAMPLE_BITS-1] ? (~x + 1'b1) : x;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/l2vn_in_if.sv
// ----------------------------------------------------------------------------
// L2 vector normalizer sample channel
// Valid/ready channel that carries one channel value per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface l2vn_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [l2vn_pkg::SAMPLE_BITS-1:0] sample;
	logic                                    last_of_vector;

	modport source(output valid, output sample, output last_of_vector, input ready);
	modport sink(input valid, input sample, input last_of_vector, output ready);
endinterface

`default_nettype wire

FILE: hdl/l2vn_out_if.sv
// ----------------------------------------------------------------------------
// L2 vector normalizer result channel
// Valid/ready channel that carries one normalized value per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface l2vn_out_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [l2vn_pkg::SAMPLE_BITS-1:0] normalized;
	logic                                    last_of_run;
	logic                                    zero_norm;
	logic                                    overflow;

	modport source(output valid, output normalized, output last_of_run,
		output zero_norm, output overflow, input ready);
	modport sink(input valid, input normalized, input last_of_run,
		input zero_norm, input overflow, output ready);
endinterface

`default_nettype wire

FILE: hdl/l2vn_rsqrt.sv
// ----------------------------------------------------------------------------
// L2 vector normalizer reciprocal square root
// Restoring divide of 2^62 by the square sum, one quotient bit per cycle,
// followed by a digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module l2vn_rsqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [l2vn_pkg::SUM_W-1:0] sum,
	output l2vn_pkg::rs_stat_t         stat
);

	l2vn_pkg::rs_state_t state_q, state_d;

	logic [l2vn_pkg::SUM_W-1:0]   div_q;
	logic [l2vn_pkg::SUM_W-1:0]   rem_q;
	logic [l2vn_pkg::QUO_W-1:0]   quo_q;
	logic [l2vn_pkg::QSTEP_W-1:0] dstep_q;
	logic [l2vn_pkg::WORK_W-1:0]  v_q;
	logic [l2vn_pkg::WORK_W-1:0]  res_q;
	logic [l2vn_pkg::WORK_W-1:0]  bit_q;
	logic [l2vn_pkg::RSTEP_W-1:0] rstep_q;

	logic                         dbit;
	logic [l2vn_pkg::SUM_W:0]     trial;
	logic [l2vn_pkg::SUM_W:0]     trial_sub;
	logic                         qbit;
	logic [l2vn_pkg::SUM_W-1:0]   rem_nx;
	logic [l2vn_pkg::QUO_W-1:0]   quo_nx;
	logic [l2vn_pkg::WORK_W-1:0]  tsum;
	logic                         take;

	assign dbit      = (dstep_q == l2vn_pkg::QSTEP_W'(l2vn_pkg::QUO_W - 1));
	assign trial     = {rem_q, dbit};
	assign trial_sub = trial - {1'b0, div_q};
	assign qbit      = (trial >= {1'b0, div_q});
	assign rem_nx    = qbit ? trial_sub[l2vn_pkg::SUM_W-1:0] : trial[l2vn_pkg::SUM_W-1:0];
	assign quo_nx    = {quo_q[l2vn_pkg::QUO_W-2:0], qbit};
	assign tsum      = res_q + bit_q;
	assign take      = (v_q >= tsum);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			l2vn_pkg::RS_IDLE: begin
				if (start) begin
					state_d = l2vn_pkg::RS_DIV;
				end
			end
			l2vn_pkg::RS_DIV: begin
				if (dstep_q == '0) begin
					state_d = l2vn_pkg::RS_ROOT;
				end
			end
			l2vn_pkg::RS_ROOT: begin
				if (rstep_q == '0) begin
					state_d = l2vn_pkg::RS_DONE;
				end
			end
			l2vn_pkg::RS_DONE: begin
				state_d = l2vn_pkg::RS_IDLE;
			end
			default: begin
				state_d = l2vn_pkg::RS_IDLE;
			end
		endcase
	end

	always_comb begin
		stat.done = (state_q == l2vn_pkg::RS_DONE);
		stat.root = res_q[l2vn_pkg::ROOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= l2vn_pkg::RS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			l2vn_pkg::RS_IDLE: begin
				if (start) begin
					div_q   <= sum;
					rem_q   <= '0;
					quo_q   <= '0;
					dstep_q <= l2vn_pkg::QSTEP_W'(l2vn_pkg::QUO_W - 1);
				end
			end
			l2vn_pkg::RS_DIV: begin
				rem_q   <= rem_nx;
				quo_q   <= quo_nx;
				dstep_q <= dstep_q - 1'b1;
				if (dstep_q == '0) begin
					v_q     <= l2vn_pkg::WORK_W'(quo_nx);
					res_q   <= '0;
					bit_q   <= l2vn_pkg::WORK_W'(1) << (l2vn_pkg::WORK_W - 2);
					rstep_q <= l2vn_pkg::RSTEP_W'(l2vn_pkg::ROOT_W - 1);
				end
			end
			l2vn_pkg::RS_ROOT: begin
				if (take) begin
					v_q   <= v_q - tsum;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q   <= bit_q >> 2;
				rstep_q <= rstep_q - 1'b1;
			end
			l2vn_pkg::RS_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/l2vn_fifo.sv
// ----------------------------------------------------------------------------
// L2 vector normalizer result queue
// Small register queue between the scaling pipeline and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module l2vn_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  l2vn_pkg::res_t               push_data,
	input  logic                         pop,
	output logic                         valid,
	output l2vn_pkg::res_t               head,
	output logic [l2vn_pkg::FIFO_CW-1:0] count
);

	l2vn_pkg::res_t               entry_q [l2vn_pkg::FIFO_DEPTH];
	logic [l2vn_pkg::FIFO_AW-1:0] wr_q;
	logic [l2vn_pkg::FIFO_AW-1:0] rd_q;
	logic [l2vn_pkg::FIFO_CW-1:0] count_q;

	assign valid = (count_q != '0);
	assign head  = entry_q[rd_q];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/l2_vector_normalizer_unit.sv
// After the last sample is taken the sum closes, a serial divide forms a 63-bit quotient,
// a serial root its 32-bit root, and a hand-off follows (all skipped for an all-zero vector);
// each result is then read, scaled and queued, one per cycle while results are not stalled.
// A vector is taken only after the last result of the one before is issued, paced by the
// serial divider and root unit and by the single read port of the sample store.
// Reset clears the sequencer, sum, counts and queue; the sample store is not cleared.
// ----------------------------------------------------------------------------
// L2 vector normalizer
// Stores a vector of Q1.15 samples, sums their squares, forms the reciprocal
// square root and emits every stored sample scaled to unit L2 norm.
// ----------------------------------------------------------------------------
`default_nettype none

module l2_vector_normalizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	l2vn_in_if.sink    samples,
	l2vn_out_if.source results
);

	l2vn_pkg::state_t state_q, state_d;

	logic [l2vn_pkg::SAMPLE_BITS-1:0] store_mem [l2vn_pkg::MAX_CHANNELS];

	logic [l2vn_pkg::CNT_W-1:0]       count_q;
	logic [l2vn_pkg::SUM_W-1:0]       sum_q;
	logic                             drop_q;
	logic [l2vn_pkg::SQ_W-1:0]        sq_s1;
	logic                             sq_vld_s1;

	logic [l2vn_pkg::CNT_W-1:0]       n_q;
	logic                             zero_q;
	logic                             ovf_q;
	logic [l2vn_pkg::ROOT_W-1:0]      root_q;
	logic [l2vn_pkg::CNT_W-1:0]       iss_q;

	logic [l2vn_pkg::SAMPLE_BITS-1:0] rd_s1;
	logic                             vld_s1;
	logic                             last_s1;
	logic                             zero_s1;
	logic                             ovf_s1;
	logic [l2vn_pkg::PROD_W-1:0]      prod_s2;
	logic                             neg_s2;
	logic                             vld_s2;
	logic                             last_s2;
	logic                             zero_s2;
	logic                             ovf_s2;

	logic                             acc;
	logic                             room;
	logic                             fin_go;
	logic                             sum_zero;
	logic                             rs_start;
	logic                             issue;
	logic                             last_issue;
	logic                             credit;
	logic [l2vn_pkg::SAMPLE_BITS-1:0] mag_in;
	logic [l2vn_pkg::SQ_W-1:0]        sq_c;
	logic [l2vn_pkg::SAMPLE_BITS-1:0] mag_rd;
	logic [l2vn_pkg::PROD_W-1:0]      prod_c;
	logic [l2vn_pkg::PROD_W:0]        rnd;
	logic [l2vn_pkg::Y_W-1:0]         y;
	logic [l2vn_pkg::SAMPLE_BITS-1:0] y_pos;
	logic [l2vn_pkg::SAMPLE_BITS-1:0] y_neg;
	logic [l2vn_pkg::FIFO_CW:0]       pending;

	l2vn_pkg::rs_stat_t               rs_stat;
	l2vn_pkg::res_t                   push_data;
	l2vn_pkg::res_t                   head;
	logic                             fifo_valid;
	logic [l2vn_pkg::FIFO_CW-1:0]     fifo_cnt;

	assign acc        = samples.valid && samples.ready;
	assign room       = (count_q < l2vn_pkg::CNT_W'(l2vn_pkg::MAX_CHANNELS));
	assign fin_go     = (state_q == l2vn_pkg::ST_FINISH) && !sq_vld_s1;
	assign sum_zero   = (sum_q == '0);
	assign last_issue = (l2vn_pkg::CNT_W'(iss_q + 1'b1) == n_q);
	assign pending    = (l2vn_pkg::FIFO_CW + 1)'(fifo_cnt) + (l2vn_pkg::FIFO_CW + 1)'(vld_s1)
		+ (l2vn_pkg::FIFO_CW + 1)'(vld_s2);
	assign credit     = (pending < (l2vn_pkg::FIFO_CW + 1)'(l2vn_pkg::FIFO_DEPTH));

	assign mag_in = l2vn_pkg::magnitude(samples.sample);
	assign sq_c   = l2vn_pkg::SQ_W'(mag_in) * l2vn_pkg::SQ_W'(mag_in);
	assign mag_rd = l2vn_pkg::magnitude(rd_s1);
	assign prod_c = l2vn_pkg::PROD_W'(mag_rd) * l2vn_pkg::PROD_W'(root_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			l2vn_pkg::ST_LOAD: begin
				if (acc && samples.last_of_vector) begin
					state_d = l2vn_pkg::ST_FINISH;
				end
			end
			l2vn_pkg::ST_FINISH: begin
				if (!sq_vld_s1) begin
					state_d = sum_zero ? l2vn_pkg::ST_EMIT : l2vn_pkg::ST_SCALE;
				end
			end
			l2vn_pkg::ST_SCALE: begin
				if (rs_stat.done) begin
					state_d = l2vn_pkg::ST_EMIT;
				end
			end
			l2vn_pkg::ST_EMIT: begin
				if (issue && last_issue) begin
					state_d = l2vn_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = l2vn_pkg::ST_LOAD;
			end
		endcase
	end

	always_comb begin
		samples.ready = (state_q == l2vn_pkg::ST_LOAD);
		rs_start      = fin_go && !sum_zero;
		issue         = (state_q == l2vn_pkg::ST_EMIT) && credit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= l2vn_pkg::ST_LOAD;
			count_q   <= '0;
			sum_q     <= '0;
			drop_q    <= 1'b0;
			sq_vld_s1 <= 1'b0;
			iss_q     <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
		end else begin
			state_q   <= state_d;
			sq_vld_s1 <= acc && room;
			vld_s1    <= issue;
			vld_s2    <= vld_s1;
			priority if (fin_go) begin
				count_q <= '0;
				sum_q   <= '0;
				drop_q  <= 1'b0;
			end else begin
				if (acc) begin
					if (room) begin
						count_q <= count_q + 1'b1;
					end else begin
						drop_q <= 1'b1;
					end
				end
				if (sq_vld_s1) begin
					sum_q <= sum_q + l2vn_pkg::SUM_W'(sq_s1);
				end
			end
			priority if (fin_go) begin
				iss_q <= '0;
			end else if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && room) begin
			store_mem[count_q[l2vn_pkg::ADDR_W-1:0]] <= samples.sample;
		end
		if (issue) begin
			rd_s1 <= store_mem[iss_q[l2vn_pkg::ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sq_s1 <= sq_c;
		end
		if (fin_go) begin
			n_q    <= count_q;
			zero_q <= sum_zero;
			ovf_q  <= drop_q;
		end
		if (rs_stat.done) begin
			root_q <= rs_stat.root;
		end
		last_s1 <= last_issue;
		zero_s1 <= zero_q;
		ovf_s1  <= ovf_q;
		prod_s2 <= prod_c;
		neg_s2  <= rd_s1[l2vn_pkg::SAMPLE_BITS-1];
		last_s2 <= last_s1;
		zero_s2 <= zero_s1;
		ovf_s2  <= ovf_s1;
	end

	always_comb begin
		rnd   = {1'b0, prod_s2} + l2vn_pkg::ROUND_ADD;
		y     = rnd[l2vn_pkg::PROD_W:l2vn_pkg::SHIFT];
		y_pos = (y > l2vn_pkg::Y_W'(l2vn_pkg::SAT_POS)) ?
			l2vn_pkg::SAT_POS : y[l2vn_pkg::SAMPLE_BITS-1:0];
		y_neg = (y > l2vn_pkg::Y_W'(l2vn_pkg::SAT_NEG)) ?
			l2vn_pkg::SAT_NEG : y[l2vn_pkg::SAMPLE_BITS-1:0];
		push_data.last_of_run = last_s2;
		push_data.zero_norm   = zero_s2;
		push_data.overflow    = ovf_s2;
		if (zero_s2) begin
			push_data.normalized = '0;
		end else if (neg_s2) begin
			push_data.normalized = ~y_neg + 1'b1;
		end else begin
			push_data.normalized = y_pos;
		end
	end

	l2vn_rsqrt u_rsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rs_start),
		.sum    (sum_q),
		.stat   (rs_stat)
	);

	l2vn_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld_s2),
		.push_data (push_data),
		.pop       (fifo_valid && results.ready),
		.valid     (fifo_valid),
		.head      (head),
		.count     (fifo_cnt)
	);

	assign results.valid       = fifo_valid;
	assign results.normalized  = head.normalized;
	assign results.last_of_run = head.last_of_run;
	assign results.zero_norm   = head.zero_norm;
	assign results.overflow    = head.overflow;

endmodule

`default_nettype wire

FILE: hdl/l2vn_checker.sv
// ----------------------------------------------------------------------------
// L2 vector normalizer port checker
// Watches the sample and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "l2_vector_normalizer_unit_macros.svh"

module l2vn_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_ready,
	input logic                                    in_last,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic signed [l2vn_pkg::SAMPLE_BITS-1:0] normalized,
	input logic                                    last_of_run,
	input logic                                    zero_norm,
	input logic                                    overflow
);

	logic                             mid_q;
	logic                             prev_zero_q;
	logic                             prev_ovf_q;
	logic                             out_stall;
	logic                             end_req;
	logic                             flags_same;
	logic [l2vn_pkg::SAMPLE_BITS+2:0] out_word;

	assign out_stall  = out_valid && !out_ready;
	assign end_req    = in_valid && in_ready && in_last;
	assign flags_same = (zero_norm == prev_zero_q) && (overflow == prev_ovf_q);
	assign out_word   = {normalized, last_of_run, zero_norm, overflow};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q       <= 1'b0;
			prev_zero_q <= 1'b0;
			prev_ovf_q  <= 1'b0;
		end else if (out_valid && out_ready) begin
			mid_q       <= !last_of_run;
			prev_zero_q <= zero_norm;
			prev_ovf_q  <= overflow;
		end
	end

	`L2VN_ASSERT_NXT(a_out_hold, out_stall, out_valid, "result request dropped")
	`L2VN_ASSERT_NXT(a_out_stable, out_stall, $stable(out_word), "stalled result changed")
	`L2VN_ASSERT_IMP(a_run_flags, out_valid && mid_q, flags_same, "flags changed within a run")
	`L2VN_ASSERT_IMP(a_zero_out, out_valid && zero_norm, normalized == '0, "zero-norm result nonzero")
	`L2VN_ASSERT_NXT(a_end_stall, end_req, !in_ready, "sample taken while closing a vector")

endmodule

bind l2_vector_normalizer_unit l2vn_checker u_l2vn_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.in_last     (samples.last_of_vector),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.normalized  (results.normalized),
	.last_of_run (results.last_of_run),
	.zero_norm   (results.zero_norm),
	.overflow    (results.overflow)
);

`default_nettype wire
